@@ src/qnc_pkg.sv @@
`default_nettype none

package qnc_pkg;

   // input item codes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_TAKE   = 1'b1;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_EDGES_PER_NOTCH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERT_DIRECTION = 1'd1;
   localparam int unsigned CSR_DATA_W = 8;

   localparam logic [7:0] EDGES_PER_NOTCH_RESET = 8'd4;

   // pending count limits and widths
   localparam int COUNT_LIMIT = 4000;
   localparam int unsigned PEND_W = 13;
   localparam int unsigned RESID_W = 9;
   localparam int unsigned DIVISOR_W = 8;
   localparam int unsigned NOTCH_W = 14;
   // magnitude of residual plus pending, one quotient bit per divider step
   localparam int unsigned MAG_W = 13;
   localparam int unsigned STEP_W = $clog2(MAG_W);

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   typedef struct packed {
      logic is_take;
      logic step_en;
      logic step_down;
   } qnc_entry_type;

endpackage

`default_nettype wire

@@ src/quadrature_notch_counter_core.sv @@
`default_nettype none

// channel  direction  beat                                   flow control
// req      in         operation, level_a, level_b            req_valid / req_stall
// rsp      out        notch_delta (one per take)             rsp_valid / rsp_stall
// csr      in         csr_index, csr_wdata                   csr_write_enable
//
// a beat enters the front queue; the back end retires one sample per cycle unless a take
// waits at the queue head for the divider, which runs operand load, 13 one-bit divider
// steps and output load; samples behind a take keep being counted while the divider runs
// req_stall rises only when the queue (QUEUE_DEPTH beats) is full
// synchronous reset clears levels, counts, queue and output valid; edges_per_notch resets to 4

module quadrature_notch_counter_core #(
   parameter int unsigned QUEUE_DEPTH = qnc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic                            req_operation,
   input  wire logic                            req_level_a,
   input  wire logic                            req_level_b,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic signed [qnc_pkg::NOTCH_W-1:0]   rsp_notch_delta,
   input  wire logic                            csr_write_enable,
   input  wire logic [qnc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [qnc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import qnc_pkg::*;

   logic [DIVISOR_W-1:0] edges_per_notch_ff, edges_per_notch_in;
   logic                 invert_direction_ff, invert_direction_in;

   logic          push_valid;
   qnc_entry_type push_entry;
   logic          queue_full;
   logic          queue_empty;
   logic          pop;
   qnc_entry_type head_entry;

   always_comb begin
      edges_per_notch_in  = edges_per_notch_ff;
      invert_direction_in = invert_direction_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_EDGES_PER_NOTCH:  edges_per_notch_in  = csr_wdata[DIVISOR_W-1:0];
            CSR_INVERT_DIRECTION: invert_direction_in = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edges_per_notch_ff  <= EDGES_PER_NOTCH_RESET;
         invert_direction_ff <= 1'b0;
      end else begin
         edges_per_notch_ff  <= edges_per_notch_in;
         invert_direction_ff <= invert_direction_in;
      end
   end

   qnc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_level_a   (req_level_a),
      .req_level_b   (req_level_b),
      .queue_full    (queue_full),
      .push_valid    (push_valid),
      .push_entry    (push_entry)
   );

   qnc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .empty      (queue_empty),
      .pop        (pop),
      .head_entry (head_entry)
   );

   qnc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .queue_empty      (queue_empty),
      .head_entry       (head_entry),
      .pop              (pop),
      .edges_per_notch  (edges_per_notch_ff),
      .invert_direction (invert_direction_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_notch_delta  (rsp_notch_delta)
   );

endmodule

`default_nettype wire

@@ src/qnc_front.sv @@
`default_nettype none

module qnc_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_operation,
   input  wire logic                  req_level_a,
   input  wire logic                  req_level_b,
   input  wire logic                  queue_full,
   output logic                       push_valid,
   output qnc_pkg::qnc_entry_type     push_entry
);
   import qnc_pkg::*;

   logic last_a_ff, last_a_in;
   logic last_b_ff, last_b_in;
   logic a_chg, b_chg;
   logic is_sample;

   assign req_stall  = queue_full;
   assign push_valid = req_valid && !queue_full;
   assign is_sample  = (req_operation == OP_SAMPLE);

   assign a_chg = req_level_a != last_a_ff;
   assign b_chg = req_level_b != last_b_ff;

   always_comb begin
      push_entry.is_take = (req_operation == OP_TAKE);
      push_entry.step_en = is_sample && (a_chg ^ b_chg);
      // a alone counts down when a equals b, b alone counts down when they differ
      if (a_chg) begin
         push_entry.step_down = ~(req_level_a ^ req_level_b);
      end else begin
         push_entry.step_down = req_level_a ^ req_level_b;
      end
   end

   always_comb begin
      last_a_in = last_a_ff;
      last_b_in = last_b_ff;
      if (push_valid && is_sample) begin
         last_a_in = req_level_a;
         last_b_in = req_level_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_a_ff <= 1'b0;
         last_b_ff <= 1'b0;
      end else begin
         last_a_ff <= last_a_in;
         last_b_ff <= last_b_in;
      end
   end

endmodule

`default_nettype wire

@@ src/qnc_queue.sv @@
`default_nettype none

module qnc_queue #(
   parameter int unsigned DEPTH = qnc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push_valid,
   input  wire qnc_pkg::qnc_entry_type push_entry,
   output logic                       full,
   output logic                       empty,
   input  wire logic                  pop,
   output qnc_pkg::qnc_entry_type     head_entry
);
   import qnc_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   qnc_entry_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign empty      = (count_ff == '0);
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && !empty;
   assign head_entry = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

@@ src/qnc_back.sv @@
`default_nettype none

module qnc_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          queue_empty,
   input  wire qnc_pkg::qnc_entry_type        head_entry,
   output logic                               pop,
   input  wire logic [qnc_pkg::DIVISOR_W-1:0] edges_per_notch,
   input  wire logic                          invert_direction,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [qnc_pkg::NOTCH_W-1:0] rsp_notch_delta
);
   import qnc_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   localparam logic signed [PEND_W-1:0] PEND_MAX = PEND_W'(COUNT_LIMIT);
   localparam logic signed [PEND_W-1:0] PEND_MIN = PEND_W'(-COUNT_LIMIT);

   logic [1:0] state_ff, state_in;
   logic signed [PEND_W-1:0]  pending_ff, pending_in;
   logic signed [RESID_W-1:0] residual_ff, residual_in;
   logic [MAG_W-1:0]     quo_ff, quo_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] divisor_ff, divisor_in;
   logic                 neg_ff, neg_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [NOTCH_W-1:0] rsp_notch_ff, rsp_notch_in;

   logic signed [NOTCH_W-1:0] total;
   logic [NOTCH_W-1:0]        total_mag;
   logic [DIVISOR_W:0]        trial;
   logic [DIVISOR_W:0]        trial_sub;
   logic                      out_free;
   logic                      start_take;
   logic                      apply_step;
   logic [NOTCH_W-1:0]        quo_ext;
   logic [RESID_W-1:0]        rem_ext;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_notch_delta = rsp_notch_ff;
   assign out_free        = !rsp_valid_ff || !rsp_stall;

   // samples keep flowing while the divider works; a take waits for it
   assign pop        = !queue_empty && (!head_entry.is_take || state_ff == ST_IDLE);
   assign start_take = pop && head_entry.is_take;
   assign apply_step = pop && !head_entry.is_take && head_entry.step_en;

   assign total = NOTCH_W'(residual_ff) + NOTCH_W'(pending_ff);
   assign total_mag = total[NOTCH_W-1] ? -total : total;

   // one restoring step: shift the next dividend bit into the remainder
   assign trial     = {rem_ff, quo_ff[MAG_W-1]};
   assign trial_sub = trial - {1'b0, divisor_ff};

   assign quo_ext = NOTCH_W'(quo_ff);
   assign rem_ext = RESID_W'(rem_ff);

   always_comb begin
      state_in     = state_ff;
      pending_in   = pending_ff;
      residual_in  = residual_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      divisor_in   = divisor_ff;
      neg_in       = neg_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_notch_in = rsp_notch_ff;

      if (apply_step) begin
         if (head_entry.step_down) begin
            if (pending_ff != PEND_MIN) begin
               pending_in = pending_ff - 1'b1;
            end
         end else begin
            if (pending_ff != PEND_MAX) begin
               pending_in = pending_ff + 1'b1;
            end
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (start_take) begin
               pending_in = '0;
               neg_in     = total[NOTCH_W-1];
               quo_in     = total_mag[MAG_W-1:0];
               rem_in     = '0;
               divisor_in = (edges_per_notch == '0) ? DIVISOR_W'(1) : edges_per_notch;
               step_in    = '0;
               state_in   = ST_RUN;
            end
         end
         ST_RUN: begin
            if (!trial_sub[DIVISOR_W]) begin
               rem_in = trial_sub[DIVISOR_W-1:0];
               quo_in = {quo_ff[MAG_W-2:0], 1'b1};
            end else begin
               rem_in = trial[DIVISOR_W-1:0];
               quo_in = {quo_ff[MAG_W-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(MAG_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_notch_in = (neg_ff ^ invert_direction) ? -quo_ext : quo_ext;
               residual_in  = neg_ff ? -rem_ext : rem_ext;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pending_ff   <= '0;
         residual_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         residual_ff  <= residual_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      divisor_ff   <= divisor_in;
      neg_ff       <= neg_in;
      step_ff      <= step_in;
      rsp_notch_ff <= rsp_notch_in;
   end

endmodule

`default_nettype wire

@@ tb/quadrature_notch_counter_core_tb.sv @@
`timescale 1ns / 1ps

module quadrature_notch_counter_core_tb;
   import qnc_pkg::*;

   localparam int QUIET_CYCLES = 40;
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int REPORT_MAX   = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic                        req_operation = OP_SAMPLE;
   logic                        req_level_a = 1'b0;
   logic                        req_level_b = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic signed [NOTCH_W-1:0]   rsp_notch_delta;
   logic                        csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]      csr_index = CSR_EDGES_PER_NOTCH;
   logic [CSR_DATA_W-1:0]       csr_wdata = '0;

   quadrature_notch_counter_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_level_a      (req_level_a),
      .req_level_b      (req_level_b),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_notch_delta  (rsp_notch_delta),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #4 clock = ~clock;

   // decoder state as the testbench sees it
   logic [7:0] notch_div = EDGES_PER_NOTCH_RESET;
   logic       notch_invert = 1'b0;
   logic       prev_a = 1'b0;
   logic       prev_b = 1'b0;
   int         edge_pending = 0;
   int         edge_carry = 0;
   logic signed [NOTCH_W-1:0] notch_expect_q[$];

   int   mismatches = 0;
   int   burst_left = 0;
   logic hold_request = 1'b0;
   int   hold_left = 0;
   int   stall_mode = 0;
   int   stall_left = 0;
   int   cycles = 0;

   function automatic int quad_step(input logic pa, input logic pb,
                                    input logic a, input logic b);
      int d;
      d = 0;
      if (a != pa && b == pb) begin
         d = a ? -1 : 1;
         if (!b) d = -d;
      end else if (b != pb && a == pa) begin
         d = b ? 1 : -1;
         if (!a) d = -d;
      end
      return d;
   endfunction

   task automatic count_beat(input logic op, input logic a, input logic b);
      int div;
      int total;
      int notches;
      if (op == OP_SAMPLE) begin
         edge_pending = edge_pending + quad_step(prev_a, prev_b, a, b);
         if (edge_pending > COUNT_LIMIT) edge_pending = COUNT_LIMIT;
         if (edge_pending < -COUNT_LIMIT) edge_pending = -COUNT_LIMIT;
         prev_a = a;
         prev_b = b;
      end else begin
         div = (notch_div == 8'd0) ? 1 : int'(notch_div);
         total = edge_carry + edge_pending;
         notches = total / div;
         edge_carry = total - notches * div;
         edge_pending = 0;
         if (notch_invert) notches = -notches;
         notch_expect_q.push_back(notches[NOTCH_W-1:0]);
      end
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_EDGES_PER_NOTCH) notch_div = data;
      else notch_invert = data[0];
      @(posedge clock);
   endtask

   task automatic set_config(input logic [7:0] div, input logic [7:0] invert_word);
      csr_write(CSR_EDGES_PER_NOTCH, div);
      csr_write(CSR_INVERT_DIRECTION, invert_word);
   endtask

   // valid stays up from one beat to the next unless a gap starts here
   task automatic send_beat(input logic op, input logic a, input logic b);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 16);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_operation <= op;
      req_level_a <= a;
      req_level_b <= b;
      do @(posedge clock); while (req_stall);
      count_beat(op, a, b);
   endtask

   // one quadrature step, forward is 00 -> 10 -> 11 -> 01
   task automatic turn(input bit fwd);
      logic [1:0] nxt;
      case ({prev_a, prev_b})
         2'b00: nxt = fwd ? 2'b10 : 2'b01;
         2'b10: nxt = fwd ? 2'b11 : 2'b00;
         2'b11: nxt = fwd ? 2'b01 : 2'b10;
         default: nxt = fwd ? 2'b00 : 2'b11;
      endcase
      send_beat(OP_SAMPLE, nxt[1], nxt[0]);
   endtask

   task automatic take_notches();
      send_beat(OP_TAKE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (notch_expect_q.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic check_notch(input logic signed [NOTCH_W-1:0] got);
      logic signed [NOTCH_W-1:0] want;
      if (notch_expect_q.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_MAX)
            $display("notch_delta %0d arrived with nothing outstanding", got);
      end else begin
         want = notch_expect_q.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("notch_delta mismatch: expected %0d got %0d", want, got);
         end
      end
   endtask

   // result side: check each beat, then pick the stall for the next cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) check_notch(rsp_notch_delta);
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(8, 80);
      end
      stall_left--;
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic test_reset_state();
      take_notches();
      send_beat(OP_SAMPLE, 1'b0, 1'b0);
      take_notches();
   endtask

   task automatic test_each_edge();
      drain();
      set_config(8'd1, 8'd0);
      for (int i = 0; i < 4; i++) turn(1'b1);
      take_notches();
      for (int i = 0; i < 4; i++) turn(1'b0);
      take_notches();
      // both pins at once, then no change at all, then a mix of one-pin and two-pin changes
      send_beat(OP_SAMPLE, 1'b1, 1'b1);
      send_beat(OP_SAMPLE, 1'b1, 1'b1);
      send_beat(OP_SAMPLE, 1'b0, 1'b1);
      send_beat(OP_SAMPLE, 1'b1, 1'b0);
      send_beat(OP_SAMPLE, 1'b0, 1'b0);
      // chatter on one pin cancels out
      send_beat(OP_SAMPLE, 1'b1, 1'b0);
      send_beat(OP_SAMPLE, 1'b0, 1'b0);
      take_notches();
   endtask

   task automatic test_divisor();
      drain();
      set_config(8'd0, 8'd0);
      for (int i = 0; i < 7; i++) turn(1'b1);
      take_notches();
      drain();
      set_config(8'd3, 8'hfe);
      for (int i = 0; i < 5; i++) turn(1'b0);
      take_notches();
      turn(1'b1);
      take_notches();
      drain();
      csr_write(CSR_INVERT_DIRECTION, 8'h01);
      for (int i = 0; i < 4; i++) turn(1'b1);
      take_notches();
      drain();
      set_config(8'd255, 8'h00);
      for (int i = 0; i < 9; i++) turn(1'b0);
      take_notches();
   endtask

   task automatic test_backpressure();
      drain();
      set_config(8'd2, 8'd0);
      hold_request = 1'b1;
      for (int i = 0; i < 80; i++) begin
         if (i % 4 == 3) take_notches();
         else turn($urandom_range(0, 3) != 0);
      end
      // hold the sender until every result is back
      drain();
      for (int i = 0; i < 20; i++) begin
         if (i % 5 == 4) take_notches();
         else turn(1'b0);
      end
   endtask

   task automatic test_random();
      int n;
      int run;
      bit fwd;
      logic [7:0] div;
      for (int phase = 0; phase < 4; phase++) begin
         drain();
         case ($urandom_range(0, 5))
            0: div = 8'd0;
            1: div = 8'd1;
            2: div = 8'd255;
            default: div = 8'($urandom_range(2, 8));
         endcase
         set_config(div, 8'($urandom_range(0, 255)));
         n = 0;
         while (n < 100) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5, 6: begin
                  run = $urandom_range(1, 12);
                  fwd = 1'($urandom_range(0, 1));
                  for (int i = 0; i < run; i++) turn(fwd);
                  n += run;
               end
               7: begin
                  take_notches();
                  n++;
               end
               default: begin
                  send_beat(OP_SAMPLE, 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)));
                  n++;
               end
            endcase
         end
         take_notches();
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_each_edge();
      test_divisor();
      test_backpressure();
      test_random();
      drain();
      mismatches += notch_expect_q.size();
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ sim.f @@
src/qnc_pkg.sv
src/qnc_front.sv
src/qnc_queue.sv
src/qnc_back.sv
src/quadrature_notch_counter_core.sv
tb/quadrature_notch_counter_core_tb.sv
